FILE: hdl/crcfr_pkg.sv
// shared types, codes and the crc byte update for the crc checked frame receiver
package crcfr_pkg;

    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [15:0] CRC_INIT        = 16'h0000;
    localparam logic [15:0] CRC_MSB         = 16'h8000;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd8192;
    localparam logic [7:0]  MARKER_RST      = 8'h00;

    // configuration register indexes
    localparam logic [1:0] REG_MARKER      = 2'd0;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd1;

    typedef enum logic [2:0] {
        EV_PASS      = 3'd0,
        EV_TAKEN     = 3'd1,
        EV_PAYLOAD   = 3'd2,
        EV_GOOD      = 3'd3,
        EV_MISMATCH  = 3'd4,
        EV_TOO_LARGE = 3'd5
    } t_event;

    typedef struct packed {
        logic [7:0]  marker_byte;
        logic [15:0] max_payload;
    } t_cfg;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  data_out;
        logic [15:0] payload_index;
        logic [7:0]  frm_type;
        logic [7:0]  slot_number;
        logic [15:0] frame_length;
        logic [15:0] crc_received;
        logic [15:0] crc_computed;
    } t_result;

    // crc-16 xmodem, msb first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/crc_checked_frame_receiver.sv
// top level of the crc checked frame receiver
// Takes one received byte per word on the s_axis side and gives exactly one result word per
// byte on the m_axis side, one byte per clock sustained while m_axis_tready is high: frame
// state and byte-wide crc-16 xmodem update are combinational; each result is registered as
// its byte is taken. A two-entry output buffer lets input continue while a result waits. The
// marker byte (register 0, reset 0) opens a frame of type, slot and little-endian length,
// then payload and a little-endian crc; lengths above max_payload (register 1, reset 8192)
// are rejected on the last header byte. Registers are written through the cfg channel,
// which is always ready, and should change only while no frame is in progress.
module crc_checked_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // data_out, payload_index, frm_type, slot_number, frame_length, crc_received,
    // crc_computed
    output logic [87:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // event_res
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    crcfr_pkg::t_cfg    r_cfg;
    crcfr_pkg::t_result parse_res;
    crcfr_pkg::t_result out_res;
    logic               take;

    assign o_cfg_ready = 1'b1;
    assign take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.marker_byte <= crcfr_pkg::MARKER_RST;
            r_cfg.max_payload <= crcfr_pkg::MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == crcfr_pkg::REG_MARKER) begin
                r_cfg.marker_byte <= i_cfg_data[7:0];
            end else if (i_cfg_index == crcfr_pkg::REG_MAX_PAYLOAD) begin
                r_cfg.max_payload <= i_cfg_data;
            end
        end
    end

    crcfr_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (s_axis_tdata),
        .i_cfg   (r_cfg),
        .o_res   (parse_res)
    );

    crcfr_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (take),
        .i_res       (parse_res),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_res       (out_res)
    );

    assign m_axis_tuser = out_res.event_res;
    assign m_axis_tdata = {out_res.crc_computed, out_res.crc_received, out_res.frame_length,
                           out_res.slot_number, out_res.frm_type, out_res.payload_index,
                           out_res.data_out};

endmodule

FILE: hdl/crcfr_parser.sv
// frame state machine: header capture, payload streaming and crc check
module crcfr_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [7:0]         i_byte,
    input  crcfr_pkg::t_cfg    i_cfg,
    output crcfr_pkg::t_result o_res
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CRC     = 2'd3
    } t_phase;

    localparam logic [1:0] HDR_TYPE   = 2'd0;
    localparam logic [1:0] HDR_SLOT   = 2'd1;
    localparam logic [1:0] HDR_LEN_LO = 2'd2;
    localparam logic [1:0] HDR_LEN_HI = 2'd3;

    t_phase      r_phase,    n_phase;
    logic [1:0]  r_hdr_cnt,  n_hdr_cnt;
    logic [7:0]  r_type,     n_type;
    logic [7:0]  r_slot,     n_slot;
    logic [15:0] r_len,      n_len;
    logic [15:0] r_cnt,      n_cnt;
    logic [15:0] r_crc,      n_crc;
    logic [7:0]  r_crc_lo,   n_crc_lo;
    logic        r_seen,     n_seen;
    logic [15:0] crc_byte;
    logic [15:0] rx_crc;

    assign crc_byte = crcfr_pkg::crc16_byte(r_crc, i_byte);
    assign rx_crc   = {i_byte, r_crc_lo};

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_type    = r_type;
        n_slot    = r_slot;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_crc     = r_crc;
        n_crc_lo  = r_crc_lo;
        n_seen    = r_seen;
        o_res     = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_byte == i_cfg.marker_byte) begin
                    n_phase         = PH_HEADER;
                    n_hdr_cnt       = HDR_TYPE;
                    n_crc           = crcfr_pkg::CRC_INIT;
                    o_res.event_res = crcfr_pkg::EV_TAKEN;
                end else begin
                    o_res.event_res = crcfr_pkg::EV_PASS;
                    o_res.data_out  = i_byte;
                end
            end
            PH_HEADER: begin
                n_crc = crc_byte;
                unique case (r_hdr_cnt)
                    HDR_TYPE:   n_type = i_byte;
                    HDR_SLOT:   n_slot = i_byte;
                    HDR_LEN_LO: n_len  = {r_len[15:8], i_byte};
                    HDR_LEN_HI: n_len  = {i_byte, r_len[7:0]};
                    default:    n_len  = r_len;
                endcase
                if (r_hdr_cnt == HDR_LEN_HI) begin
                    n_hdr_cnt = HDR_TYPE;
                    if (n_len > i_cfg.max_payload) begin
                        o_res.event_res    = crcfr_pkg::EV_TOO_LARGE;
                        o_res.frm_type     = n_type;
                        o_res.slot_number  = n_slot;
                        o_res.frame_length = n_len;
                        o_res.crc_computed = n_crc;
                        n_phase            = PH_IDLE;
                    end else begin
                        o_res.event_res = crcfr_pkg::EV_TAKEN;
                        n_cnt           = '0;
                        n_seen          = 1'b0;
                        n_phase         = (n_len == 16'd0) ? PH_CRC : PH_PAYLOAD;
                    end
                end else begin
                    n_hdr_cnt       = r_hdr_cnt + 2'd1;
                    o_res.event_res = crcfr_pkg::EV_TAKEN;
                end
            end
            PH_PAYLOAD: begin
                n_crc               = crc_byte;
                o_res.event_res     = crcfr_pkg::EV_PAYLOAD;
                o_res.data_out      = i_byte;
                o_res.payload_index = r_cnt;
                o_res.frm_type      = r_type;
                o_res.slot_number   = r_slot;
                o_res.frame_length  = r_len;
                o_res.crc_computed  = crc_byte;
                n_cnt               = r_cnt + 16'd1;
                // a wrapped count also ends the payload
                if (n_cnt >= r_len || n_cnt == 16'd0) begin
                    n_phase = PH_CRC;
                    n_seen  = 1'b0;
                end
            end
            PH_CRC: begin
                if (!r_seen) begin
                    n_crc_lo        = i_byte;
                    n_seen          = 1'b1;
                    o_res.event_res = crcfr_pkg::EV_TAKEN;
                end else begin
                    n_seen             = 1'b0;
                    o_res.event_res    = (rx_crc == r_crc) ? crcfr_pkg::EV_GOOD
                                                           : crcfr_pkg::EV_MISMATCH;
                    o_res.frm_type     = r_type;
                    o_res.slot_number  = r_slot;
                    o_res.frame_length = r_len;
                    o_res.crc_received = rx_crc;
                    o_res.crc_computed = r_crc;
                    n_phase            = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_hdr_cnt <= '0;
            r_type    <= '0;
            r_slot    <= '0;
            r_len     <= '0;
            r_cnt     <= '0;
            r_crc     <= '0;
            r_crc_lo  <= '0;
            r_seen    <= 1'b0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_type    <= n_type;
            r_slot    <= n_slot;
            r_len     <= n_len;
            r_cnt     <= n_cnt;
            r_crc     <= n_crc;
            r_crc_lo  <= n_crc_lo;
            r_seen    <= n_seen;
        end
    end

`ifndef SYNTHESIS
    a_hdr_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HEADER) |-> (r_hdr_cnt == HDR_TYPE))
        else $error("header count nonzero outside header phase");

    a_too_large_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && o_res.event_res == crcfr_pkg::EV_TOO_LARGE) |=> (r_phase == PH_IDLE))
        else $error("oversized frame did not return to idle");

    a_payload_in_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.event_res == crcfr_pkg::EV_PAYLOAD) |-> (r_phase == PH_PAYLOAD))
        else $error("payload word outside payload phase");
`endif

endmodule

FILE: hdl/crcfr_outbuf.sv
// two-entry output buffer that decouples the result stream from the input side
module crcfr_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  crcfr_pkg::t_result i_res,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_pop_ready,
    output crcfr_pkg::t_result o_res
);

    logic               r_out_v;
    logic               r_skid_v;
    crcfr_pkg::t_result r_out;
    crcfr_pkg::t_result r_skid;
    logic               pop;

    assign o_ready = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_res   = r_out;
    assign pop     = r_out_v && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (pop && r_skid_v) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end else if (pop) begin
                r_out_v <= i_push;
                if (i_push) begin
                    r_out <= i_res;
                end
            end else if (i_push) begin
                if (!r_out_v) begin
                    r_out   <= i_res;
                    r_out_v <= 1'b1;
                end else begin
                    r_skid   <= i_res;
                    r_skid_v <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: bench/tb_crc_checked_frame_receiver.sv
// testbench for the crc checked frame receiver: framed byte streams checked against a predictor
`timescale 1ns / 1ps

module tb_crc_checked_frame_receiver;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CRC     = 2'd3
    } t_rx_phase;

    // predicts one result word per received byte and checks the block's results in order
    class frame_rx_checker;
        bit [7:0]  marker;
        bit [15:0] max_len;
        t_rx_phase phase;
        bit [1:0]  hdr_cnt;
        bit [7:0]  blk_type;
        bit [7:0]  slot;
        bit [15:0] len;
        bit [15:0] pay_cnt;
        bit [15:0] crc;
        bit [7:0]  crc_lo;
        bit        crc_lo_seen;
        crcfr_pkg::t_result pending_results[$];
        int        errors;
        int        bytes_taken;

        function new();
            marker      = crcfr_pkg::MARKER_RST;
            max_len     = crcfr_pkg::MAX_PAYLOAD_RST;
            phase       = PH_IDLE;
            hdr_cnt     = '0;
            blk_type    = '0;
            slot        = '0;
            len         = '0;
            pay_cnt     = '0;
            crc         = crcfr_pkg::CRC_INIT;
            crc_lo      = '0;
            crc_lo_seen = 1'b0;
            errors      = 0;
            bytes_taken = 0;
        endfunction

        // xmodem crc, one data bit at a time
        static function bit [15:0] crc_step(bit [15:0] c, bit [7:0] d);
            bit fb;
            for (int k = 7; k >= 0; k--) begin
                fb = c[15] ^ d[k];
                c  = {c[14:0], 1'b0};
                if (fb) begin
                    c = c ^ crcfr_pkg::CRC_POLY;
                end
            end
            return c;
        endfunction

        function bit busy();
            return phase != PH_IDLE;
        endfunction

        function void set_reg(bit [1:0] idx, bit [15:0] data);
            case (idx)
                crcfr_pkg::REG_MARKER:      marker  = data[7:0];
                crcfr_pkg::REG_MAX_PAYLOAD: max_len = data;
                default: ;
            endcase
        endfunction

        function void fill_frame(ref crcfr_pkg::t_result r);
            r.frm_type     = blk_type;
            r.slot_number  = slot;
            r.frame_length = len;
            r.crc_computed = crc;
        endfunction

        function void take_byte(bit [7:0] b);
            crcfr_pkg::t_result r;
            bit [15:0]          rx_crc;
            r = '0;
            r.event_res = crcfr_pkg::EV_PASS;
            bytes_taken++;
            case (phase)
                PH_IDLE: begin
                    if (b == marker) begin
                        phase       = PH_HEADER;
                        hdr_cnt     = '0;
                        crc         = crcfr_pkg::CRC_INIT;
                        r.event_res = crcfr_pkg::EV_TAKEN;
                    end else begin
                        r.data_out = b;
                    end
                end
                PH_HEADER: begin
                    crc = crc_step(crc, b);
                    case (hdr_cnt)
                        2'd0: blk_type  = b;
                        2'd1: slot      = b;
                        2'd2: len[7:0]  = b;
                        2'd3: len[15:8] = b;
                    endcase
                    if (hdr_cnt == 2'd3) begin
                        hdr_cnt = '0;
                        if (len > max_len) begin
                            r.event_res = crcfr_pkg::EV_TOO_LARGE;
                            fill_frame(r);
                            phase = PH_IDLE;
                        end else begin
                            r.event_res = crcfr_pkg::EV_TAKEN;
                            pay_cnt     = '0;
                            crc_lo_seen = 1'b0;
                            phase       = (len == 16'd0) ? PH_CRC : PH_PAYLOAD;
                        end
                    end else begin
                        hdr_cnt++;
                        r.event_res = crcfr_pkg::EV_TAKEN;
                    end
                end
                PH_PAYLOAD: begin
                    crc = crc_step(crc, b);
                    r.event_res     = crcfr_pkg::EV_PAYLOAD;
                    r.data_out      = b;
                    r.payload_index = pay_cnt;
                    fill_frame(r);
                    pay_cnt++;
                    if (pay_cnt >= len || pay_cnt == 16'd0) begin
                        phase       = PH_CRC;
                        crc_lo_seen = 1'b0;
                    end
                end
                PH_CRC: begin
                    if (!crc_lo_seen) begin
                        crc_lo      = b;
                        crc_lo_seen = 1'b1;
                        r.event_res = crcfr_pkg::EV_TAKEN;
                    end else begin
                        rx_crc      = {b, crc_lo};
                        crc_lo_seen = 1'b0;
                        r.event_res = (rx_crc == crc) ? crcfr_pkg::EV_GOOD
                                                      : crcfr_pkg::EV_MISMATCH;
                        fill_frame(r);
                        r.crc_received = rx_crc;
                        phase = PH_IDLE;
                    end
                end
            endcase
            pending_results.push_back(r);
        endfunction

        function void match_result(logic [2:0] ev, logic [87:0] data);
            crcfr_pkg::t_result want;
            crcfr_pkg::t_result got;
            bit                 bad;
            got.event_res     = crcfr_pkg::t_event'(ev);
            got.data_out      = data[7:0];
            got.payload_index = data[23:8];
            got.frm_type      = data[31:24];
            got.slot_number   = data[39:32];
            got.frame_length  = data[55:40];
            got.crc_received  = data[71:56];
            got.crc_computed  = data[87:72];
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result word: ev=%0d data=%h", ev, data);
                end
                return;
            end
            want = pending_results.pop_front();
            bad = (got.event_res !== want.event_res) || (got.data_out !== want.data_out)
                || (got.payload_index !== want.payload_index)
                || (got.frm_type !== want.frm_type)
                || (got.slot_number !== want.slot_number)
                || (got.frame_length !== want.frame_length)
                || (got.crc_received !== want.crc_received)
                || (got.crc_computed !== want.crc_computed);
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp: ev=%0d byte=%h idx=%h type=%h slot=%h len=%h rx=%h crc=%h",
                             want.event_res, want.data_out, want.payload_index, want.frm_type,
                             want.slot_number, want.frame_length, want.crc_received,
                             want.crc_computed);
                    $display("         got: ev=%0d byte=%h idx=%h type=%h slot=%h len=%h rx=%h crc=%h",
                             ev, got.data_out, got.payload_index, got.frm_type,
                             got.slot_number, got.frame_length, got.crc_received,
                             got.crc_computed);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // byte_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // data_out, payload_index, frm_type, slot_number, frame_length, crc_received,
    // crc_computed
    logic [87:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;            // event_res
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = crcfr_pkg::REG_MARKER;
    logic [15:0] i_cfg_data    = 16'h0000;

    bit              gaps_on  = 1'b1;
    frame_rx_checker rx_check = new();

    crc_checked_frame_receiver u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side stalls
    always @(posedge i_clk) begin
        m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 13);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_check.match_result(m_axis_tuser, m_axis_tdata);
        end
    end

    task automatic send_byte(input bit [7:0] b);
        if (gaps_on && $urandom_range(0, 99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= b;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        rx_check.take_byte(b);
    endtask

    // lets every pending result come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (rx_check.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        rx_check.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    // keep < 0 sends the whole frame, otherwise only the first keep bytes;
    // an unfinished frame is closed with zero bytes
    task automatic send_frame(input bit [7:0] kind, input bit [7:0] slot_no,
                              input bit [15:0] len, input bit bad_crc, input int keep);
        bit [7:0]  frm[$];
        bit [7:0]  hdr[4];
        bit [7:0]  pb;
        bit [15:0] c;
        hdr[0] = kind;
        hdr[1] = slot_no;
        hdr[2] = len[7:0];
        hdr[3] = len[15:8];
        c = crcfr_pkg::CRC_INIT;
        frm.push_back(rx_check.marker);
        foreach (hdr[i]) begin
            frm.push_back(hdr[i]);
            c = frame_rx_checker::crc_step(c, hdr[i]);
        end
        if (len <= rx_check.max_len) begin
            for (int i = 0; i < len; i++) begin
                pb = 8'($urandom);
                frm.push_back(pb);
                c = frame_rx_checker::crc_step(c, pb);
            end
            if (bad_crc) begin
                c = c ^ (16'h0001 << $urandom_range(0, 15));
            end
            frm.push_back(c[7:0]);
            frm.push_back(c[15:8]);
        end
        if (keep >= 0) begin
            while (frm.size() > keep) void'(frm.pop_back());
        end
        foreach (frm[i]) send_byte(frm[i]);
        while (rx_check.busy()) send_byte(8'h00);
    endtask

    task automatic run_random(input int quota);
        int        stop_at;
        int        pick;
        int        cap;
        bit [15:0] len;
        bit [7:0]  nb;
        stop_at = rx_check.bytes_taken + quota;
        while (rx_check.bytes_taken < stop_at) begin
            pick = int'($urandom_range(0, 99));
            cap  = (rx_check.max_len < 24) ? int'(rx_check.max_len) : 24;
            if ($urandom_range(0, 19) == 0) begin
                cap = (rx_check.max_len < 300) ? int'(rx_check.max_len) : 300;
            end
            len = 16'($urandom_range(0, cap));
            if (pick < 15) begin
                nb = 8'($urandom);
                if (nb == rx_check.marker) begin
                    nb = nb ^ 8'h01;
                end
                send_byte(nb);
            end else if (pick < 72) begin
                send_frame(8'($urandom), 8'($urandom), len, 1'b0, -1);
            end else if (pick < 80 && rx_check.max_len != 16'hFFFF) begin
                send_frame(8'($urandom), 8'($urandom),
                           16'($urandom_range(int'(rx_check.max_len) + 1, 65535)), 1'b0, -1);
            end else if (pick < 90) begin
                send_frame(8'($urandom), 8'($urandom), len, 1'b1, -1);
            end else begin
                send_frame(8'($urandom), 8'($urandom), len, 1'b0,
                           int'($urandom_range(1, int'(len) + 6)));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: passthrough, empty frame, bad crc, oversize header
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_frame(8'hFF, 8'h00, 16'd0, 1'b0, -1);
        send_frame(8'h00, 8'hFF, 16'd2, 1'b1, -1);
        send_frame(8'h12, 8'h34, 16'hFFFF, 1'b0, -1);

        write_reg(crcfr_pkg::REG_MARKER, 16'h00FF);
        write_reg(crcfr_pkg::REG_MAX_PAYLOAD, 16'h0000);
        send_frame(8'hA5, 8'h5A, 16'd0, 1'b0, -1);
        send_frame(8'hA5, 8'h5A, 16'd1, 1'b0, -1);
        run_random(300);

        // no idling on either side in this stretch
        write_reg(crcfr_pkg::REG_MARKER, {8'h00, 8'($urandom)});
        write_reg(crcfr_pkg::REG_MAX_PAYLOAD, 16'hFFFF);
        gaps_on = 1'b0;
        run_random(330);
        drain();
        gaps_on = 1'b1;

        write_reg(crcfr_pkg::REG_MARKER, 16'h007E);
        write_reg(crcfr_pkg::REG_MAX_PAYLOAD, 16'd5);
        send_frame(8'h01, 8'h02, 16'd5, 1'b0, -1);
        send_frame(8'h01, 8'h02, 16'd6, 1'b0, -1);
        run_random(330);

        write_reg(crcfr_pkg::REG_MARKER, {8'h00, crcfr_pkg::MARKER_RST});
        write_reg(crcfr_pkg::REG_MAX_PAYLOAD, crcfr_pkg::MAX_PAYLOAD_RST);
        run_random(330);

        write_reg(crcfr_pkg::REG_MARKER, {8'h00, 8'($urandom)});
        write_reg(crcfr_pkg::REG_MAX_PAYLOAD, 16'($urandom_range(24, 300)));
        run_random(330);

        drain();
        repeat (10) @(posedge i_clk);
        if (rx_check.errors == 0 && rx_check.pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/crcfr_pkg.sv
hdl/crcfr_parser.sv
hdl/crcfr_outbuf.sv
hdl/crc_checked_frame_receiver.sv
bench/tb_crc_checked_frame_receiver.sv
